// ===== hw/rtl/ecgbd_pkg.sv =====
// ---------------------------------------------------------------------------
// ecgbd_pkg
// shared types, constants and biquad coefficient table of the beat detector
// ---------------------------------------------------------------------------
package ecgbd_pkg;

    // baseline ring, power of two length
    localparam int WINDOW_LEN = 256;
    localparam int RING_AW    = $clog2(WINDOW_LEN);
    localparam int SUM_W      = 12 + RING_AW;

    // biquad cascade, history kept four words per section
    localparam int SECTIONS = 3;
    localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int ST_DEPTH = 4 * SECTIONS;
    localparam int ST_AW    = $clog2(ST_DEPTH);

    // history slots within a section
    localparam logic [1:0] SLOT_X1 = 2'd0;
    localparam logic [1:0] SLOT_X2 = 2'd1;
    localparam logic [1:0] SLOT_Y1 = 2'd2;
    localparam logic [1:0] SLOT_Y2 = 2'd3;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DECAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_DECAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_FRACTION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_FRACTION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_MULTIPLIER = 3'd4;

    localparam logic [15:0] RST_WINDOW_DECAY    = 16'd655;
    localparam logic [15:0] RST_THRESHOLD_DECAY = 16'd66;
    localparam logic [15:0] RST_UPPER_FRACTION  = 16'd39322;
    localparam logic [15:0] RST_LOWER_FRACTION  = 16'd26214;
    localparam logic [7:0]  RST_RATE_MULTIPLIER = 8'd6;

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic        func;
        logic [11:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] filtered;
        logic signed [31:0] band_min;
        logic signed [31:0] band_max;
        logic               beat_start;
        logic               in_beat;
        logic [15:0]        beats_per_minute;
    } t_out_word;

    typedef struct packed {
        logic acc_en;
        logic acc_clr;
    } t_mac_ctl;

    // term order: b0*x0, b1*x1, b2*x2, -a1*y1, -a2*y2 (feedback terms pre-negated)
    function automatic logic signed [31:0] coef(input logic [2:0] sec,
                                                input logic [2:0] term);
        logic signed [31:0] c;
        c = 32'sd0;
        case (sec)
            3'd0: begin
                case (term)
                    3'd0:    c = 32'sd2403;
                    3'd1:    c = 32'sd4806;
                    3'd2:    c = 32'sd2403;
                    3'd3:    c = 32'sd2122714239;
                    3'd4:    c = -32'sd1049923387;
                    default: c = 32'sd0;
                endcase
            end
            3'd1: begin
                case (term)
                    3'd0:    c = Q30_ONE;
                    3'd2:    c = -Q30_ONE;
                    3'd3:    c = 32'sd2119348316;
                    3'd4:    c = -32'sd1045773850;
                    default: c = 32'sd0;
                endcase
            end
            3'd2: begin
                case (term)
                    3'd0:    c = Q30_ONE;
                    3'd1:    c = 32'sh8000_0000;
                    3'd2:    c = Q30_ONE;
                    3'd3:    c = 32'sd2143215052;
                    3'd4:    c = -32'sd1069503066;
                    default: c = 32'sd0;
                endcase
            end
            default: begin
                // pass-through section
                c = (term == 3'd0) ? Q30_ONE : 32'sd0;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/ecgbd_ram.sv =====
// ---------------------------------------------------------------------------
// ecgbd_ram
// generic simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module ecgbd_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ecgbd_mac.sv =====
// ---------------------------------------------------------------------------
// ecgbd_mac
// shared multiplier with registered product and wide accumulator
// ---------------------------------------------------------------------------
module ecgbd_mac (
    input  logic                    i_clk,
    input  logic signed [32:0]      i_a,
    input  logic signed [31:0]      i_b,
    input  ecgbd_pkg::t_mac_ctl     i_ctl,
    output logic signed [64:0]      o_prod,
    output logic signed [67:0]      o_acc
);

    logic signed [64:0] r_prod;
    logic signed [67:0] r_acc;
    logic signed [67:0] n_acc;

    // accumulator adds the product of the previous cycle
    always_comb begin
        n_acc = (i_ctl.acc_clr ? 68'sd0 : r_acc) + 68'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== hw/rtl/ecg_beat_detector_unit.sv =====
// ---------------------------------------------------------------------------
// ecg_beat_detector_unit
// ecg beat detector: baseline removal, biquad cascade, envelopes, hysteresis
// ---------------------------------------------------------------------------
// path: a sample word goes through S_RING, one S_SEC pass per section, S_ENV
// and S_EMIT from acceptance to output; a rate tick goes straight to S_EMIT
// flow: one word at a time, a new word only after S_EMIT has passed the last
// to a free output register; the shared multiplier walks five terms per
// section and the history memory's one write port takes four write-backs each
// reset: synchronous active low, clears control state, envelopes and config;
// ring and history memories are masked by a fill flag and valid bits
// ---------------------------------------------------------------------------
module ecg_beat_detector_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  ecgbd_pkg::t_in_word                    i_in_word,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output ecgbd_pkg::t_out_word                   o_out_word,
    input  logic                                   i_cfg_we,
    input  logic [ecgbd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ecgbd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RING = 3'd1;
    localparam logic [2:0] S_SEC  = 3'd2;
    localparam logic [2:0] S_ENV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam int RAW_W = ecgbd_pkg::SUM_W + 16;

    // config registers
    logic [15:0] r_wdecay, r_tdecay, r_ufrac, r_lfrac;
    logic [7:0]  r_mult;

    // control
    logic [2:0]                       r_state;
    logic [3:0]                       r_cnt;
    logic [ecgbd_pkg::SEC_W-1:0]      r_sec;
    logic [ecgbd_pkg::RING_AW-1:0]    r_pos;
    logic                             r_full;
    logic [ecgbd_pkg::SUM_W-1:0]      r_sum;
    logic [ecgbd_pkg::ST_DEPTH-1:0]   r_st_vld;
    logic                             r_rd_ok;
    logic                             r_ovld;

    // detector state
    logic signed [31:0] r_filt, r_emax, r_emin, r_bup, r_blo;
    logic               r_flag;
    logic [15:0]        r_tally, r_bpm;

    // payload working registers
    logic [11:0]               r_raw;
    logic signed [31:0]        r_x, r_x1, r_y1, r_y;
    logic                      r_gt, r_lt;
    logic signed [33:0]        r_thh;
    ecgbd_pkg::t_out_word      r_res, r_out;

    // memories
    logic                             ring_we;
    logic [11:0]                      ring_rdata;
    logic                             st_we;
    logic [ecgbd_pkg::ST_AW-1:0]      st_waddr, st_raddr;
    logic signed [31:0]               st_wdata;
    logic [31:0]                      st_rdata;
    logic signed [31:0]               hist;

    // mac
    logic signed [32:0]     mac_a;
    logic signed [31:0]     mac_b;
    ecgbd_pkg::t_mac_ctl    mac_ctl;
    logic signed [64:0]     prod;
    logic signed [67:0]     acc;

    // combinational helpers
    logic                           in_acc;
    logic [11:0]                    ring_old;
    logic [ecgbd_pkg::SUM_W-1:0]    n_sum;
    logic [RAW_W-1:0]               avg, raw_ext, base_diff;
    logic [1:0]                     wslot;
    logic signed [67:0]             acc_rnd;
    logic signed [37:0]             y_wide;
    logic signed [31:0]             y_sat, filt_neg;
    logic signed [31:0]             decay_step;
    logic signed [33:0]             frac_step, thl, filt34;
    logic signed [32:0]             width;
    logic                           started, flag_in, leaving;
    logic [23:0]                    bpm_raw;
    logic [15:0]                    bpm_sat;
    logic                           last_sec;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    ecgbd_ram #(
        .W (12),
        .D (ecgbd_pkg::WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_pos),
        .i_wdata (r_raw),
        .i_raddr (r_pos),
        .o_rdata (ring_rdata)
    );

    ecgbd_ram #(
        .W (32),
        .D (ecgbd_pkg::ST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    ecgbd_mac u_mac (
        .i_clk  (i_clk),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .i_ctl  (mac_ctl),
        .o_prod (prod),
        .o_acc  (acc)
    );

    // ring update and baseline subtraction
    always_comb begin
        ring_we   = (r_state == S_RING);
        ring_old  = r_full ? ring_rdata : 12'd0;
        n_sum     = r_sum - ecgbd_pkg::SUM_W'(ring_old) + ecgbd_pkg::SUM_W'(r_raw);
        avg       = RAW_W'({n_sum, 16'h0000} >> ecgbd_pkg::RING_AW);
        raw_ext   = RAW_W'({r_raw, 16'h0000});
        base_diff = raw_ext - avg;
    end

    // history memory addressing: reads on steps 0..3, write-back on 6..9
    always_comb begin
        wslot    = 2'(r_cnt - 4'd6);
        st_raddr = ecgbd_pkg::ST_AW'({r_sec, r_cnt[1:0]});
        st_waddr = ecgbd_pkg::ST_AW'({r_sec, wslot});
        st_we    = (r_state == S_SEC) && (r_cnt >= 4'd6);
        hist     = r_rd_ok ? $signed(st_rdata) : 32'sd0;
        case (wslot)
            ecgbd_pkg::SLOT_X1: st_wdata = r_x;
            ecgbd_pkg::SLOT_X2: st_wdata = r_x1;
            ecgbd_pkg::SLOT_Y1: st_wdata = r_y;
            default:            st_wdata = r_y1;
        endcase
        last_sec = (r_sec == ecgbd_pkg::SEC_W'(ecgbd_pkg::SECTIONS - 1));
    end

    // round to nearest (ties up) from q2.30 and saturate
    always_comb begin
        acc_rnd = acc + 68'sh2000_0000;
        y_wide  = 38'(acc_rnd >>> 30);
        if (y_wide > 38'sd2147483647) begin
            y_sat = 32'sh7fff_ffff;
        end else if (y_wide < -38'sd2147483648) begin
            y_sat = 32'sh8000_0000;
        end else begin
            y_sat = y_wide[31:0];
        end
        filt_neg = (r_y == 32'sh8000_0000) ? 32'sh7fff_ffff : -r_y;
    end

    // shared multiplier operand selection
    always_comb begin
        mac_a   = 33'sd0;
        mac_b   = 32'sd0;
        mac_ctl = '0;
        if (r_state == S_SEC) begin
            mac_a = (r_cnt == 4'd0) ? 33'(r_x) : 33'(hist);
            mac_b = ecgbd_pkg::coef(3'(r_sec), r_cnt[2:0]);
            mac_ctl.acc_en  = (r_cnt >= 4'd1) && (r_cnt <= 4'd5);
            mac_ctl.acc_clr = (r_cnt == 4'd1);
        end else if (r_state == S_ENV) begin
            case (r_cnt)
                4'd0: begin
                    mac_a = 33'(r_filt) - 33'(r_emax);
                    mac_b = 32'(r_wdecay);
                end
                4'd1: begin
                    mac_a = 33'(r_filt) - 33'(r_bup);
                    mac_b = 32'(r_tdecay);
                end
                4'd2: begin
                    mac_a = 33'(r_filt) - 33'(r_emin);
                    mac_b = 32'(r_wdecay);
                end
                4'd3: begin
                    mac_a = 33'(r_filt) - 33'(r_blo);
                    mac_b = 32'(r_tdecay);
                end
                4'd5: begin
                    mac_a = width;
                    mac_b = 32'(r_ufrac);
                end
                4'd6: begin
                    mac_a = width;
                    mac_b = 32'(r_lfrac);
                end
                default: begin
                    mac_a = 33'sd0;
                    mac_b = 32'sd0;
                end
            endcase
        end
    end

    // envelope, threshold and hysteresis arithmetic
    always_comb begin
        decay_step = 32'(prod >>> 16);
        frac_step  = 34'(prod >>> 16);
        width      = 33'(r_bup) - 33'(r_blo);
        thl        = 34'(r_blo) + frac_step;
        filt34     = 34'(r_filt);
        started    = (filt34 > r_thh) && !r_flag;
        flag_in    = r_flag || started;
        leaving    = (filt34 < thl) && flag_in;
        bpm_raw    = 24'(r_tally) * 24'(r_mult);
        bpm_sat    = (bpm_raw > 24'd65535) ? 16'hffff : bpm_raw[15:0];
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wdecay <= ecgbd_pkg::RST_WINDOW_DECAY;
            r_tdecay <= ecgbd_pkg::RST_THRESHOLD_DECAY;
            r_ufrac  <= ecgbd_pkg::RST_UPPER_FRACTION;
            r_lfrac  <= ecgbd_pkg::RST_LOWER_FRACTION;
            r_mult   <= ecgbd_pkg::RST_RATE_MULTIPLIER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ecgbd_pkg::CFG_WINDOW_DECAY:    r_wdecay <= i_cfg_wdata;
                ecgbd_pkg::CFG_THRESHOLD_DECAY: r_tdecay <= i_cfg_wdata;
                ecgbd_pkg::CFG_UPPER_FRACTION:  r_ufrac  <= i_cfg_wdata;
                ecgbd_pkg::CFG_LOWER_FRACTION:  r_lfrac  <= i_cfg_wdata;
                ecgbd_pkg::CFG_RATE_MULTIPLIER: r_mult   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_st_vld[st_raddr];
        if (in_acc) begin
            r_raw <= i_in_word.sample;
        end
        if (in_acc && i_in_word.func) begin
            r_res.filtered         <= r_filt;
            r_res.band_min         <= r_emin;
            r_res.band_max         <= r_emax;
            r_res.beat_start       <= 1'b0;
            r_res.in_beat          <= r_flag;
            r_res.beats_per_minute <= bpm_sat;
        end
        if (r_state == S_RING) begin
            r_x <= base_diff[31:0];
        end
        if (r_state == S_SEC) begin
            if (r_cnt == 4'd1) r_x1 <= hist;
            if (r_cnt == 4'd3) r_y1 <= hist;
            if (r_cnt == 4'd6) r_y  <= y_sat;
            if (r_cnt == 4'd9) r_x  <= r_y;
        end
        if (r_state == S_ENV) begin
            if (r_cnt == 4'd0) begin
                r_gt <= r_filt > r_emax;
                r_lt <= r_filt < r_emin;
            end
            if (r_cnt == 4'd6) r_thh <= 34'(r_blo) + frac_step;
            if (r_cnt == 4'd7) begin
                r_res.filtered         <= r_filt;
                r_res.band_min         <= r_emin;
                r_res.band_max         <= r_emax;
                r_res.beat_start       <= started;
                r_res.in_beat          <= flag_in && !leaving;
                r_res.beats_per_minute <= r_bpm;
            end
        end
        if ((r_state == S_EMIT) && (!r_ovld || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    // sequencer and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 4'd0;
            r_sec    <= '0;
            r_pos    <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_st_vld <= '0;
            r_ovld   <= 1'b0;
            r_filt   <= 32'sd0;
            r_emax   <= 32'sd0;
            r_emin   <= 32'sd0;
            r_bup    <= 32'sd0;
            r_blo    <= 32'sd0;
            r_flag   <= 1'b0;
            r_tally  <= 16'd0;
            r_bpm    <= 16'd0;
        end else begin
            // output register: load a new word or drain the taken one
            if ((r_state == S_EMIT) && (!r_ovld || i_out_ready)) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_word.func) begin
                            // rate window closes
                            r_bpm   <= bpm_sat;
                            r_tally <= 16'd0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_RING;
                        end
                    end
                end
                S_RING: begin
                    r_sum <= n_sum;
                    r_pos <= r_pos + 1'b1;
                    if (&r_pos) r_full <= 1'b1;
                    r_sec   <= '0;
                    r_cnt   <= 4'd0;
                    r_state <= S_SEC;
                end
                S_SEC: begin
                    if (st_we) r_st_vld[st_waddr] <= 1'b1;
                    if (r_cnt == 4'd9) begin
                        r_cnt <= 4'd0;
                        if (last_sec) begin
                            r_filt  <= filt_neg;
                            r_state <= S_ENV;
                        end else begin
                            r_sec <= r_sec + 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_ENV: begin
                    r_cnt <= r_cnt + 4'd1;
                    case (r_cnt)
                        4'd1: r_emax <= r_gt ? r_filt : r_emax + decay_step;
                        4'd2: r_bup  <= r_gt ? r_filt : r_bup + decay_step;
                        4'd3: r_emin <= r_lt ? r_filt : r_emin + decay_step;
                        4'd4: r_blo  <= r_lt ? r_filt : r_blo + decay_step;
                        4'd7: begin
                            if (started && (r_tally != 16'hffff)) begin
                                r_tally <= r_tally + 16'd1;
                            end
                            r_flag  <= flag_in && !leaving;
                            r_state <= S_EMIT;
                        end
                        default: ;
                    endcase
                end
                S_EMIT: begin
                    if (!r_ovld || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;

endmodule

// ===== hw/rtl/ecgbd_chk.sv =====
// ---------------------------------------------------------------------------
// ecgbd_chk
// port level checks of the beat detector, bound to the top level
// ---------------------------------------------------------------------------
module ecgbd_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input ecgbd_pkg::t_in_word   i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input ecgbd_pkg::t_out_word  o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // one word in flight: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice back to back");

    // envelopes bracket the filtered signal
    a_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.band_min <= o_out_word.filtered)
                         && (o_out_word.filtered <= o_out_word.band_max)))
        else $error("envelope does not bracket filtered value");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ecg_beat_detector_unit ecgbd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// checks the ecg beat detector against a bit-exact behavioural predictor:
// directed extremes and ticks, then random ecg-like pulse trains with noise,
// under several register settings and random stalls on both channels
// ---------------------------------------------------------------------------
module tb;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    ecgbd_pkg::t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    ecgbd_pkg::t_out_word out_word;
    logic      cfg_we = 1'b0;
    logic [ecgbd_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [ecgbd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int unsigned fail_count = 0;
    ecgbd_pkg::t_out_word expected_words[$];

    // predictor state
    logic [15:0] p_win_decay, p_thr_decay, p_up_frac, p_lo_frac;
    logic [7:0]  p_rate_mul;
    logic [11:0] p_ring[ecgbd_pkg::WINDOW_LEN];
    int unsigned p_pos, p_sum;
    longint      p_x[2*ecgbd_pkg::SECTIONS];
    longint      p_y[2*ecgbd_pkg::SECTIONS];
    longint      p_env_max, p_env_min, p_base_up, p_base_lo;
    bit          p_flag;
    int unsigned p_tally, p_rate;
    int unsigned out_stall_max = 3;

    ecg_beat_detector_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic longint floor_div16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // own coefficient table, b0 b1 b2 a1 a2 in q2.30
    function automatic longint biquad_coef(int sec, int k);
        longint t[3][5] = '{
            '{2403, 4806, 2403, -2122714239, 1049923387},
            '{1073741824, 0, -1073741824, -2119348316, 1045773850},
            '{1073741824, -64'sd2147483648, 1073741824, -2143215052, 1069503066}};
        if (sec < 3) return t[sec][k];
        return (k == 0) ? 64'sd1073741824 : 64'sd0;
    endfunction

    function automatic longint decay_step(longint v, longint s, logic [15:0] rate);
        return v + floor_div16((s - v) * longint'(rate));
    endfunction

    function automatic void predictor_reset();
        p_win_decay = ecgbd_pkg::RST_WINDOW_DECAY;
        p_thr_decay = ecgbd_pkg::RST_THRESHOLD_DECAY;
        p_up_frac   = ecgbd_pkg::RST_UPPER_FRACTION;
        p_lo_frac   = ecgbd_pkg::RST_LOWER_FRACTION;
        p_rate_mul  = ecgbd_pkg::RST_RATE_MULTIPLIER;
        foreach (p_ring[i]) p_ring[i] = '0;
        foreach (p_x[i]) begin
            p_x[i] = 0;
            p_y[i] = 0;
        end
        p_pos = 0; p_sum = 0;
        p_env_max = 0; p_env_min = 0; p_base_up = 0; p_base_lo = 0;
        p_flag = 0; p_tally = 0; p_rate = 0;
    endfunction

    // works out the detector output for one accepted word
    function automatic ecgbd_pkg::t_out_word predict_detector(ecgbd_pkg::t_in_word w);
        ecgbd_pkg::t_out_word r;
        longint v, filt, width, th_hi, th_lo;
        longint avg, hi, lo;
        longint terms[5];
        r = '0;
        if (w.func) begin
            p_rate = p_tally * p_rate_mul;
            if (p_rate > 65535) p_rate = 65535;
            p_tally = 0;
            filt = sat32(-p_y[2*(ecgbd_pkg::SECTIONS-1)]);
        end else begin
            p_sum = p_sum - p_ring[p_pos] + w.sample;
            p_ring[p_pos] = w.sample;
            p_pos = (p_pos + 1) % ecgbd_pkg::WINDOW_LEN;
            avg = (longint'(p_sum) << 16) / ecgbd_pkg::WINDOW_LEN;
            v = longint'(int'((longint'(w.sample) << 16) - avg));
            for (int s = 0; s < ecgbd_pkg::SECTIONS; s++) begin
                // exact sum split in whole and fraction parts, round half up
                terms[0] = biquad_coef(s, 0) * v;
                terms[1] = biquad_coef(s, 1) * p_x[2*s];
                terms[2] = biquad_coef(s, 2) * p_x[2*s+1];
                terms[3] = -(biquad_coef(s, 3) * p_y[2*s]);
                terms[4] = -(biquad_coef(s, 4) * p_y[2*s+1]);
                hi = 0;
                lo = 0;
                foreach (terms[k]) begin
                    hi += terms[k] >>> 30;
                    lo += terms[k] & 64'h3FFF_FFFF;
                end
                p_x[2*s+1] = p_x[2*s];
                p_x[2*s]   = v;
                p_y[2*s+1] = p_y[2*s];
                v = sat32(hi + ((lo + 64'sd536870912) >>> 30));
                p_y[2*s]   = v;
            end
            filt = sat32(-v);
            if (filt > p_env_max) begin
                p_env_max = filt;
                p_base_up = filt;
            end else begin
                p_env_max = decay_step(p_env_max, filt, p_win_decay);
                p_base_up = decay_step(p_base_up, filt, p_thr_decay);
            end
            if (filt < p_env_min) begin
                p_env_min = filt;
                p_base_lo = filt;
            end else begin
                p_env_min = decay_step(p_env_min, filt, p_win_decay);
                p_base_lo = decay_step(p_base_lo, filt, p_thr_decay);
            end
            width = p_base_up - p_base_lo;
            th_hi = p_base_lo + floor_div16(width * longint'(p_up_frac));
            th_lo = p_base_lo + floor_div16(width * longint'(p_lo_frac));
            if (filt > th_hi && !p_flag) begin
                if (p_tally < 65535) p_tally++;
                p_flag = 1;
                r.beat_start = 1'b1;
            end
            if (filt < th_lo && p_flag) p_flag = 0;
        end
        r.filtered = filt[31:0];
        r.band_min = p_env_min[31:0];
        r.band_max = p_env_max[31:0];
        r.in_beat = p_flag;
        r.beats_per_minute = p_rate[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // random gap: mostly none or short, now and then long
    function automatic int unsigned gap_len(int unsigned long_max);
        int unsigned p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(long_max, 4);
    endfunction

    // result checker, ready driven on the falling edge
    always @(posedge clk) begin
        ecgbd_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 0, 1);
            end else begin
                want = expected_words.pop_front();
                if (out_word.filtered !== want.filtered)
                    report_mismatch("filtered", out_word.filtered, want.filtered);
                if (out_word.band_min !== want.band_min)
                    report_mismatch("band_min", out_word.band_min, want.band_min);
                if (out_word.band_max !== want.band_max)
                    report_mismatch("band_max", out_word.band_max, want.band_max);
                if (out_word.beat_start !== want.beat_start)
                    report_mismatch("beat_start", out_word.beat_start, want.beat_start);
                if (out_word.in_beat !== want.in_beat)
                    report_mismatch("in_beat", out_word.in_beat, want.in_beat);
                if (out_word.beats_per_minute !== want.beats_per_minute)
                    report_mismatch("bpm", out_word.beats_per_minute,
                                    want.beats_per_minute);
            end
        end
    end

    // receiver stalls, phases of free running between
    initial begin
        int unsigned g;
        forever begin
            @(negedge clk);
            if (out_stall_max == 0) begin
                out_ready <= 1'b1;
            end else begin
                g = gap_len(out_stall_max * 20);
                if (g == 0) begin
                    out_ready <= 1'b1;
                end else begin
                    out_ready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    // sends one word, with a random gap first; valid drops only in a gap
    task automatic send_word(bit func, logic [11:0] sample, bit no_gap = 0);
        ecgbd_pkg::t_in_word w;
        int unsigned g;
        w.func = func;
        w.sample = sample;
        g = no_gap ? 0 : gap_len(60);
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_words.push_back(predict_detector(w));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(logic [ecgbd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ecgbd_pkg::CFG_WINDOW_DECAY:    p_win_decay = val;
            ecgbd_pkg::CFG_THRESHOLD_DECAY: p_thr_decay = val;
            ecgbd_pkg::CFG_UPPER_FRACTION:  p_up_frac = val;
            ecgbd_pkg::CFG_LOWER_FRACTION:  p_lo_frac = val;
            ecgbd_pkg::CFG_RATE_MULTIPLIER: p_rate_mul = val[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic write_all(logic [15:0] wd, logic [15:0] td, logic [15:0] uf,
                             logic [15:0] lf, logic [15:0] rm);
        wait_drained();
        write_reg(ecgbd_pkg::CFG_WINDOW_DECAY, wd);
        write_reg(ecgbd_pkg::CFG_THRESHOLD_DECAY, td);
        write_reg(ecgbd_pkg::CFG_UPPER_FRACTION, uf);
        write_reg(ecgbd_pkg::CFG_LOWER_FRACTION, lf);
        write_reg(ecgbd_pkg::CFG_RATE_MULTIPLIER, rm);
    endtask

    // extremes of the sample, ticks with an empty tally and after runs of samples
    task automatic test_directed();
        send_word(1, 12'hFFF);
        send_word(0, 12'h000);
        send_word(0, 12'hFFF);
        send_word(0, 12'hFFF);
        send_word(0, 12'h000);
        send_word(0, 12'hAAA);
        send_word(0, 12'h555);
        send_word(1, 12'h000);
        for (int i = 0; i < 8; i++) send_word(0, (i % 2) ? 12'hFFF : 12'h000, 1);
        send_word(1, 12'h123);
        send_word(1, 12'h000);
    endtask

    // ecg-like train: flat baseline with sharp pulses, noise, occasional ticks
    task automatic test_pulse_train(int unsigned n, int unsigned pulse_amp);
        int unsigned phase, period, base;
        logic [11:0] s;
        period = $urandom_range(60, 20);
        base = $urandom_range(2500, 1500);
        phase = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < 3) begin
                send_word(1, 12'($urandom));
            end else begin
                if ($urandom_range(99) < 5) s = 12'($urandom);
                else if (phase < 3) s = 12'(base + pulse_amp + $urandom_range(40));
                else s = 12'(base + $urandom_range(20));
                send_word(0, s, $urandom_range(3) == 0);
                phase = (phase + 1) % period;
            end
        end
    endtask

    // tally saturation not reachable quickly; large tally with max multiplier
    task automatic test_rate_saturation();
        for (int i = 0; i < 300; i++) send_word(0, (i % 4 < 2) ? 12'hFFF : 12'h000, 1);
        send_word(1, 12'h000);
    endtask

    initial begin
        predictor_reset();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_pulse_train(500, 1500);
        out_stall_max = 0;
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h00FF);
        test_rate_saturation();
        test_pulse_train(300, 2000);
        out_stall_max = 6;
        write_all(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        test_pulse_train(250, 1000);
        write_all(16'd3000, 16'd400, 16'd45000, 16'd20000, 16'd100);
        test_pulse_train(200, 1800);
        write_all(16'd655, 16'd66, 16'd39322, 16'd26214, 16'd6);
        test_pulse_train(300, 600);
        wait_drained();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
